### sv/gmca_pkg.sv
// ----------------------------------------------------------------------------
// gmca_pkg
// Shared types and constants for the greedy minimum-cost assignment block.
// ----------------------------------------------------------------------------
package gmca_pkg;

    // Default sizes of the cost matrix and of one stored cost
    localparam int DEF_MAX_ROWS   = 16;
    localparam int DEF_MAX_COLS   = 16;
    localparam int DEF_COST_WIDTH = 32;

    // Fixed field widths on the ports
    localparam int IDX_W      = 4;
    localparam int IN_COST_W  = 32;
    localparam int CNT_REG_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

    // Reset value of both count registers
    localparam logic [CNT_REG_W-1:0] CNT_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    // Status from the pass engine to the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_scan_stat;

endpackage

### sv/gmca_cost_mem.sv
// ----------------------------------------------------------------------------
// gmca_cost_mem
// Cost matrix store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gmca_cost_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

### sv/gmca_scan.sv
// ----------------------------------------------------------------------------
// gmca_scan
// Greedy pass engine: sweeps the cost store once per pass, keeps the cheapest
// free entry, then marks its row and column. Holds the row choices.
// ----------------------------------------------------------------------------
module gmca_scan #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int COST_WIDTH = 32,
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int CRW = $clog2(MAX_ROWS + 1),
    localparam int CCW = $clog2(MAX_COLS + 1),
    localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [CRW-1:0]          i_rows,
    input  logic [CCW-1:0]          i_cols,
    output logic                    o_rd_en,
    output logic [AW-1:0]           o_rd_addr,
    input  logic signed [COST_WIDTH-1:0] i_rd_data,
    input  logic [RIW-1:0]          i_emit_row,
    output logic                    o_emit_has,
    output logic [CIW-1:0]          o_emit_col,
    output gmca_pkg::t_scan_stat    o_stat
);

    import gmca_pkg::*;

    logic                         r_busy;
    logic                         r_done;
    logic [MAX_ROWS-1:0]          r_row_taken;
    logic [MAX_COLS-1:0]          r_col_taken;
    logic [CIW-1:0]               r_choice [MAX_ROWS];
    logic [RIW-1:0]               r_ir;
    logic [CIW-1:0]               r_ic;
    logic                         r_issue_done;
    logic                         r_rd_vld;
    logic [RIW-1:0]               r_tag_r;
    logic [CIW-1:0]               r_tag_c;
    logic                         r_found;
    logic signed [COST_WIDTH-1:0] r_best;
    logic [RIW-1:0]               r_br;
    logic [CIW-1:0]               r_bc;
    logic [CRW-1:0]               r_pass;

    logic issue;
    logic col_wrap;
    logic issue_last;
    logic better;
    logic pass_end;
    logic last_pass;

    always_comb begin
        issue      = r_busy && !r_issue_done;
        col_wrap   = (32'(r_ic) + 32'd1) == 32'(i_cols);
        issue_last = col_wrap && ((32'(r_ir) + 32'd1) == 32'(i_rows));
        better     = r_rd_vld && !r_row_taken[r_tag_r] && !r_col_taken[r_tag_c]
                     && (!r_found || (i_rd_data < r_best));
        pass_end   = r_busy && r_issue_done && !r_rd_vld;
        last_pass  = ((32'(r_pass) + 32'd1) == 32'(i_rows))
                     || ((32'(r_pass) + 32'd1) == 32'(i_cols));
    end

    assign o_rd_en   = issue;
    assign o_rd_addr = AW'(32'(r_ir) * MAX_COLS + 32'(r_ic));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_row_taken <= '0;
            r_col_taken <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy       <= 1'b1;
                r_row_taken  <= '0;
                r_col_taken  <= '0;
                r_found      <= 1'b0;
                r_ir         <= '0;
                r_ic         <= '0;
                r_issue_done <= 1'b0;
                r_rd_vld     <= 1'b0;
                r_pass       <= '0;
            end else if (r_busy) begin
                r_rd_vld <= issue;
                r_tag_r  <= r_ir;
                r_tag_c  <= r_ic;
                if (issue) begin
                    if (col_wrap) begin
                        r_ic <= '0;
                        r_ir <= r_ir + 1'b1;
                    end else begin
                        r_ic <= r_ic + 1'b1;
                    end
                    if (issue_last) begin
                        r_issue_done <= 1'b1;
                    end
                end
                if (better) begin
                    r_found <= 1'b1;
                    r_best  <= i_rd_data;
                    r_br    <= r_tag_r;
                    r_bc    <= r_tag_c;
                end
                // Pass complete: commit the winner and restart the sweep
                if (pass_end) begin
                    if (r_found) begin
                        r_row_taken[r_br] <= 1'b1;
                        r_col_taken[r_bc] <= 1'b1;
                        r_choice[r_br]    <= r_bc;
                    end
                    r_found      <= 1'b0;
                    r_ir         <= '0;
                    r_ic         <= '0;
                    r_issue_done <= 1'b0;
                    r_pass       <= r_pass + 1'b1;
                    if (!r_found || last_pass) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_emit_has  = r_row_taken[i_emit_row];
    assign o_emit_col  = r_choice[i_emit_row];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    // Every committed pass marks exactly one row and one column
    a_marks_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_row_taken) == $countones(r_col_taken))
        else $error("row and column mark counts differ");

    a_read_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> r_busy)
        else $error("cost read data pending outside a run");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done raised while engine still busy");

endmodule

### sv/greedy_min_cost_assignment.sv
// ----------------------------------------------------------------------------
// greedy_min_cost_assignment
// Loads a cost matrix word by word, pairs rows with columns greedily by
// lowest cost, and streams one result word per row in use.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                       handshake
//  s_axis    in   row_index, col_index, cost_value / last_entry tvalid/tready
//  m_axis    out  out_row, has_column, out_column / last_row    tvalid/tready
//  cfg       in   row_count (0), column_count (1)               i_cfg_we
//
//  Load: one word per cycle. A word with tlast starts a run of min(R, C)
//  passes, each sweeping all R*C entries through the single read port of the
//  cost memory; then R result words, one per cycle when m_axis_tready is high.
//  R and C are the row and column counts in use. Synchronous active-low
//  reset; the cost memory needs no clearing. s_axis_tready is low from the
//  tlast word until the last result word sits in the output register.
// ----------------------------------------------------------------------------
module greedy_min_cost_assignment #(
    parameter int MAX_ROWS   = gmca_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = gmca_pkg::DEF_MAX_COLS,
    parameter int COST_WIDTH = gmca_pkg::DEF_COST_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [3:0] row_index, [7:4] col_index, [39:8] cost_value
    input  logic [gmca_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [3:0] out_row, [4] has_column, [8:5] out_column, [15:9] zero
    output logic [gmca_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [gmca_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gmca_pkg::CNT_REG_W-1:0]     i_cfg_data
);

    import gmca_pkg::*;

    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CRW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state                  r_state;
    logic [CNT_REG_W-1:0]    r_row_count;
    logic [CNT_REG_W-1:0]    r_col_count;
    logic [RIW-1:0]          r_emit_row;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_row;
    logic                    r_out_has;
    logic [IDX_W-1:0]        r_out_col;
    logic                    r_out_last;

    logic [IDX_W-1:0]        in_row;
    logic [IDX_W-1:0]        in_col;
    logic                    in_take;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [COST_WIDTH-1:0]   wr_data;
    logic [CRW-1:0]          rows_eff;
    logic [CCW-1:0]          cols_eff;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [COST_WIDTH-1:0]   rd_data;
    logic                    emit_has;
    logic [CIW-1:0]          emit_col;
    logic                    emit_load;
    logic                    emit_last;
    t_scan_stat              scan_stat;

    assign in_row  = s_axis_tdata[3:0];
    assign in_col  = s_axis_tdata[7:4];
    assign in_take = s_axis_tvalid && s_axis_tready;
    // Drop words whose indexes fall outside the store
    assign wr_en   = in_take && (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
    assign wr_addr = AW'(32'(in_row) * MAX_COLS + 32'(in_col));

    generate
        if (COST_WIDTH <= IN_COST_W) begin : g_cost_trunc
            assign wr_data = s_axis_tdata[8 +: COST_WIDTH];
        end else begin : g_cost_ext
            assign wr_data = COST_WIDTH'(s_axis_tdata[39:8]);
        end
    endgenerate

    // Clamp the counts into 1..MAX
    always_comb begin
        if (r_row_count == '0) begin
            rows_eff = CRW'(1);
        end else if (32'(r_row_count) > MAX_ROWS) begin
            rows_eff = CRW'(MAX_ROWS);
        end else begin
            rows_eff = CRW'(r_row_count);
        end
        if (r_col_count == '0) begin
            cols_eff = CCW'(1);
        end else if (32'(r_col_count) > MAX_COLS) begin
            cols_eff = CCW'(MAX_COLS);
        end else begin
            cols_eff = CCW'(r_col_count);
        end
    end

    assign s_axis_tready = (r_state == ST_LOAD);
    assign emit_load     = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);
    assign emit_last     = (32'(r_emit_row) + 32'd1) == 32'(rows_eff);

    gmca_cost_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .WIDTH (COST_WIDTH)
    ) u_cost_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    gmca_scan #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .COST_WIDTH (COST_WIDTH)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_take && s_axis_tlast),
        .i_rows     (rows_eff),
        .i_cols     (cols_eff),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .i_emit_row (r_emit_row),
        .o_emit_has (emit_has),
        .o_emit_col (emit_col),
        .o_stat     (scan_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_row_count <= CNT_RESET;
            r_col_count <= CNT_RESET;
            r_emit_row  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROW_COUNT:    r_row_count <= i_cfg_data;
                    REG_COLUMN_COUNT: r_col_count <= i_cfg_data;
                    default: ;
                endcase
            end

            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_LOAD: begin
                    if (in_take && s_axis_tlast) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_stat.done) begin
                        r_state    <= ST_EMIT;
                        r_emit_row <= '0;
                    end
                end
                ST_EMIT: begin
                    // Refill the output register whenever it is free or drains
                    if (emit_load) begin
                        r_out_row   <= IDX_W'(r_emit_row);
                        r_out_has   <= emit_has;
                        r_out_col   <= emit_has ? IDX_W'(emit_col) : '0;
                        r_out_last  <= emit_last;
                        r_emit_row  <= r_emit_row + 1'b1;
                        if (emit_last) begin
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_col, r_out_has, r_out_row};
    assign m_axis_tlast  = r_out_last;

    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_stat.done |-> (r_state == ST_SCAN))
        else $error("pass engine finished outside the scan state");

    a_last_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && s_axis_tlast) |=> (r_state == ST_SCAN) && scan_stat.busy)
        else $error("tlast word did not start a run");

    a_unassigned_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has) |-> (r_out_col == '0))
        else $error("unassigned row carries a nonzero column");

endmodule
